// ===== src/trfp_pkg.sv =====
// Shared types and constants of the tag reader frame parser.
package trfp_pkg;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] DEVICE_ID  = 8'h03;
  localparam logic [7:0] STATUS_OK  = 8'h00;
  localparam logic [8:0] POS_START  = 9'd1;
  localparam logic [8:0] POS_LENGTH = 9'd2;
  localparam logic [8:0] POS_DEVICE = 9'd4;
  localparam logic [8:0] POS_STATUS = 9'd7;
  localparam logic [8:0] TAG_FIRST  = 9'd11;
  localparam logic [8:0] TAG_LAST   = 9'd18;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_DEVICE = 3'd2,
    ST_BAD_STATUS = 3'd3,
    ST_OVERFLOW   = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic          valid;
    frame_status_t status;
    logic [63:0]   tag;
    logic          match;
  } result_t;

endpackage

// ===== src/trfp_in_stage.sv =====
// Input register that holds one received byte until the parser takes it.
module trfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_byte <= rx_byte;
    end
  end

endmodule

// ===== src/trfp_parse.sv =====
// Frame parser: position, length and tag state plus the per-byte checks.
module trfp_parse #(
  parameter int MAX_FRAME = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data,
  input  logic [63:0]      expected_tag,
  output trfp_pkg::result_t result
);

  logic [7:0]  byte_position;
  logic [7:0]  frame_length;
  logic [63:0] tag_capture;
  logic [7:0]  byte_position_next;
  logic [7:0]  frame_length_next;
  logic [63:0] tag_capture_next;
  logic [8:0]  pos;
  logic        error;
  logic        done;
  trfp_pkg::frame_status_t status;

  always_comb begin
    pos               = {1'b0, byte_position} + 9'd1;
    frame_length_next = frame_length;
    tag_capture_next  = tag_capture;
    error             = 1'b0;
    status            = trfp_pkg::ST_OK;
    priority if (pos == trfp_pkg::POS_START) begin
      tag_capture_next = '0;
      if (data != trfp_pkg::START_BYTE) begin
        error  = 1'b1;
        status = trfp_pkg::ST_BAD_START;
      end
    end else if (pos == trfp_pkg::POS_LENGTH) begin
      frame_length_next = data;
    end else if (pos == trfp_pkg::POS_DEVICE) begin
      if (data != trfp_pkg::DEVICE_ID) begin
        error  = 1'b1;
        status = trfp_pkg::ST_BAD_DEVICE;
      end
    end else if (pos == trfp_pkg::POS_STATUS) begin
      if (data != trfp_pkg::STATUS_OK) begin
        error  = 1'b1;
        status = trfp_pkg::ST_BAD_STATUS;
      end
    end else if (pos >= trfp_pkg::TAG_FIRST && pos <= trfp_pkg::TAG_LAST) begin
      tag_capture_next = {tag_capture[55:0], data};
    end else begin
      tag_capture_next = tag_capture;
    end
    if (!error && pos > 9'(MAX_FRAME)) begin
      error  = 1'b1;
      status = trfp_pkg::ST_OVERFLOW;
    end
    done = !error && pos >= trfp_pkg::POS_LENGTH && pos == {1'b0, frame_length_next};
    result.valid  = error || done;
    result.status = status;
    result.tag    = error ? 64'd0 : tag_capture_next;
    result.match  = !error && (tag_capture_next == expected_tag);
    byte_position_next = (error || done) ? 8'd0 : pos[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
      tag_capture   <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      tag_capture   <= tag_capture_next;
    end
  end

endmodule

// ===== src/trfp_out_stage.sv =====
// Result register that holds one result item until the receiver takes it.
module trfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  trfp_pkg::result_t result,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        frame_status,
  output logic [63:0]       tag_value,
  output logic              tag_match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_status <= result.status;
      tag_value    <= result.tag;
      tag_match    <= result.match;
    end
  end

endmodule

// ===== src/tag_reader_frame_parser.sv =====
// Top level of the tag reader frame parser.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    rx_byte
//   out      out_valid / out_stall  frame_status, tag_value, tag_match
//   cfg      cfg_valid / cfg_ready  cfg_data (expected tag)
//
// One byte is taken per cycle while in_stall is low; a byte is held in the input register
// and its result, if any, is loaded into the result register and shown at out_valid.
// The input stalls only while a byte is held and a result waits stalled.
// Reset is synchronous and returns the parser to the first byte of a frame.
// The configuration port is always ready.
module tag_reader_frame_parser #(
  parameter int MAX_FRAME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  frame_status,
  output logic [63:0] tag_value,
  output logic        tag_match,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic              q_valid;
  logic [7:0]        q_byte;
  logic              advance;
  logic [63:0]       expected_tag;
  trfp_pkg::result_t result;

  assign cfg_ready = 1'b1;
  assign advance   = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_tag <= '0;
    end else if (cfg_valid && cfg_ready) begin
      expected_tag <= cfg_data;
    end
  end

  trfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  trfp_parse #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .data         (q_byte),
    .expected_tag (expected_tag),
    .result       (result)
  );

  trfp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && result.valid),
    .result       (result),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .tag_value    (tag_value),
    .tag_match    (tag_match)
  );

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && out_valid)
    else $error("Input stalled without a held byte and a waiting result.");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != trfp_pkg::ST_OK |-> tag_value == 64'd0 && !tag_match)
    else $error("Error result carries a tag or a match.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !q_valid)
    else $error("Stages not empty after reset.");

endmodule

// ===== sim/tag_frame_checker.sv =====
// Checker that predicts and compares the results of the tag reader frame parser.
module tag_frame_checker #(
  parameter int MAX_FRAME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  frame_status,
  input  logic [63:0] tag_value,
  input  logic        tag_match,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    trfp_pkg::frame_status_t status;
    logic [63:0]             tag;
    logic                    match;
  } frame_result_t;

  logic [7:0]    position;
  logic [7:0]    length;
  logic [63:0]   capture;
  logic [63:0]   expected_tag;
  frame_result_t pending_results[$];
  int            mismatches;

  initial begin
    position     = '0;
    length       = '0;
    capture      = '0;
    expected_tag = '0;
    mismatches   = 0;
  end

  task automatic parse_byte(input logic [7:0] b, output logic produced,
                            output frame_result_t res);
    logic [8:0]              pos;
    logic                    failed;
    trfp_pkg::frame_status_t st;
    pos      = {1'b0, position} + 9'd1;
    failed   = 1'b0;
    st       = trfp_pkg::ST_OK;
    produced = 1'b0;
    res      = '0;
    if (pos == trfp_pkg::POS_START) begin
      capture = '0;
      if (b != trfp_pkg::START_BYTE) begin
        failed = 1'b1;
        st     = trfp_pkg::ST_BAD_START;
      end
    end else if (pos == trfp_pkg::POS_LENGTH) begin
      length = b;
    end else if (pos == trfp_pkg::POS_DEVICE) begin
      if (b != trfp_pkg::DEVICE_ID) begin
        failed = 1'b1;
        st     = trfp_pkg::ST_BAD_DEVICE;
      end
    end else if (pos == trfp_pkg::POS_STATUS) begin
      if (b != trfp_pkg::STATUS_OK) begin
        failed = 1'b1;
        st     = trfp_pkg::ST_BAD_STATUS;
      end
    end else if (pos >= trfp_pkg::TAG_FIRST && pos <= trfp_pkg::TAG_LAST) begin
      capture = {capture[55:0], b};
    end
    if (!failed && pos > MAX_FRAME) begin
      failed = 1'b1;
      st     = trfp_pkg::ST_OVERFLOW;
    end
    if (failed) begin
      produced   = 1'b1;
      res.status = st;
      position   = '0;
    end else if (pos >= trfp_pkg::POS_LENGTH && pos == {1'b0, length}) begin
      produced   = 1'b1;
      res.status = trfp_pkg::ST_OK;
      res.tag    = capture;
      res.match  = (capture == expected_tag);
      position   = '0;
    end else begin
      position = pos[7:0];
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    logic          produced;
    if (rst) begin
      position     = '0;
      length       = '0;
      capture      = '0;
      expected_tag = '0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        expected_tag = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("frame_status expected none actual %0d (no frame awaiting a result)",
                 frame_status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (frame_status !== want.status) begin
            $error("frame_status expected %0d actual %0d", want.status, frame_status);
            mismatches++;
          end
          if (tag_value !== want.tag) begin
            $error("tag_value expected %h actual %h", want.tag, tag_value);
            mismatches++;
          end
          if (tag_match !== want.match) begin
            $error("tag_match expected %0b actual %0b", want.match, tag_match);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(rx_byte, produced, got);
        if (produced) begin
          pending_results.push_back(got);
        end
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: drives byte frames and tag writes into the frame parser and gives the verdict.
module tb_top;

  localparam int MAX_FRAME  = 32;
  localparam int PHASE_SIZE = 310;
  localparam int LONG_HOLD  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  frame_status;
  logic [63:0] tag_value;
  logic        tag_match;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          outstanding;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int          bytes_sent = 0;
  logic [63:0] current_tag = '0;

  tag_reader_frame_parser #(.MAX_FRAME(MAX_FRAME)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame_status(frame_status), .tag_value(tag_value), .tag_match(tag_match),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  tag_frame_checker #(.MAX_FRAME(MAX_FRAME)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame_status(frame_status), .tag_value(tag_value), .tag_match(tag_match),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver normally stalls at random, and on request holds off for a long stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (LONG_HOLD) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] len_byte, input logic [63:0] tag,
                            input trfp_pkg::frame_status_t flaw);
    int         count;
    logic [7:0] b;
    unique case (flaw)
      trfp_pkg::ST_BAD_START:  count = int'(trfp_pkg::POS_START);
      trfp_pkg::ST_BAD_DEVICE: count = int'(trfp_pkg::POS_DEVICE);
      trfp_pkg::ST_BAD_STATUS: count = int'(trfp_pkg::POS_STATUS);
      trfp_pkg::ST_OVERFLOW:   count = MAX_FRAME + 1;
      default:                 count = int'(len_byte);
    endcase
    for (int p = 1; p <= count; p++) begin
      b = 8'($urandom_range(255));
      if (p == trfp_pkg::POS_START) begin
        if (flaw == trfp_pkg::ST_BAD_START) begin
          while (b == trfp_pkg::START_BYTE) b = 8'($urandom_range(255));
        end else begin
          b = trfp_pkg::START_BYTE;
        end
      end else if (p == trfp_pkg::POS_LENGTH) begin
        b = len_byte;
      end else if (p == trfp_pkg::POS_DEVICE) begin
        if (flaw == trfp_pkg::ST_BAD_DEVICE) begin
          while (b == trfp_pkg::DEVICE_ID) b = 8'($urandom_range(255));
        end else begin
          b = trfp_pkg::DEVICE_ID;
        end
      end else if (p == trfp_pkg::POS_STATUS) begin
        if (flaw == trfp_pkg::ST_BAD_STATUS) begin
          while (b == trfp_pkg::STATUS_OK) b = 8'($urandom_range(255));
        end else begin
          b = trfp_pkg::STATUS_OK;
        end
      end else if (p >= trfp_pkg::TAG_FIRST && p <= trfp_pkg::TAG_LAST) begin
        b = tag[8 * (trfp_pkg::TAG_LAST - p) +: 8];
      end
      send_byte(b);
    end
  endtask

  // Random bytes leave the parser anywhere in a frame; a run of zero bytes always
  // ends that frame and brings it back to the first byte.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_byte(8'($urandom_range(255)));
    repeat (MAX_FRAME + 2) send_byte(8'h00);
  endtask

  task automatic send_random_frame();
    int          pick;
    logic [7:0]  len;
    logic [63:0] tag;
    pick = $urandom_range(99);
    tag  = {$urandom, $urandom};
    if ($urandom_range(99) < 25) begin
      tag = current_tag;
      if ($urandom_range(3) == 0) tag = tag ^ (64'd1 << $urandom_range(63));
    end
    if ($urandom_range(9) == 0) begin
      len = 8'($urandom_range(2, trfp_pkg::TAG_LAST - 1));
    end else begin
      len = 8'($urandom_range(trfp_pkg::TAG_LAST, MAX_FRAME));
    end
    if (pick < 60) begin
      send_frame(len, tag, trfp_pkg::ST_OK);
    end else if (pick < 67) begin
      send_frame(8'($urandom_range(255)), tag, trfp_pkg::ST_BAD_START);
    end else if (pick < 74) begin
      send_frame(8'($urandom_range(trfp_pkg::POS_DEVICE, 255)), tag,
                 trfp_pkg::ST_BAD_DEVICE);
    end else if (pick < 81) begin
      send_frame(8'($urandom_range(trfp_pkg::POS_STATUS, 255)), tag,
                 trfp_pkg::ST_BAD_STATUS);
    end else if (pick < 90) begin
      if ($urandom_range(1) == 0) begin
        len = 8'($urandom_range(1));
      end else begin
        len = 8'($urandom_range(MAX_FRAME + 1, 255));
      end
      send_frame(len, tag, trfp_pkg::ST_OVERFLOW);
    end else begin
      send_noise();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tag(input logic [63:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    current_tag = v;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic [63:0] v,
                           input logic with_hold);
    int start;
    write_tag(v);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_SIZE) begin
      if (with_hold && bytes_sent - start >= PHASE_SIZE / 3) begin
        hold_request = 1'b1;
        with_hold    = 1'b0;
      end
      send_random_frame();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hFF);
    send_byte(8'h00);
    send_frame(8'd2, '0, trfp_pkg::ST_OK);
    send_frame(8'd3, '0, trfp_pkg::ST_OK);
    send_frame(8'd4, '0, trfp_pkg::ST_BAD_DEVICE);
    send_frame(8'd7, '0, trfp_pkg::ST_BAD_STATUS);

    run_phase(0, 0, 64'h0, 1'b1);
    run_phase(51, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    run_phase(0, 51, {$urandom, $urandom}, 1'b0);
    run_phase(18, 18, {$urandom, $urandom}, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/trfp_pkg.sv
src/trfp_in_stage.sv
src/trfp_parse.sv
src/trfp_out_stage.sv
src/tag_reader_frame_parser.sv
sim/tag_frame_checker.sv
sim/tb_top.sv
